### design/gated_audio_sample_scaler_macros.svh
// Assertion macros shared by the scaler modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef GATED_AUDIO_SAMPLE_SCALER_MACROS_SVH
`define GATED_AUDIO_SAMPLE_SCALER_MACROS_SVH

// Same-cycle implication.
`define GASS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gass assertion failed");

// Next-cycle implication.
`define GASS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gass assertion failed");

`endif

### design/gass_pkg.sv
package gass_pkg;

    localparam int PhaseW     = 21;
    localparam int OffW       = 10;
    localparam int ProdW      = 18;
    localparam int SampleW    = 8;
    localparam int PeriodW    = 16;
    localparam int LevelW     = 3;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;
    localparam int GainW      = 16;
    localparam int VolProdW   = SampleW + GainW;

    // p / 704 = (p >> 6) / 11; the divide by 11 as a reciprocal multiply,
    // exact while p >> 6 stays below 2^15
    localparam int IntervalLog2 = 6;
    localparam int RecipW       = ProdW - IntervalLog2;
    localparam int RecipShift   = 15;
    localparam int RecipProdW   = 2 * RecipW;

    localparam logic [PhaseW-1:0]  IntervalUnits = PhaseW'(704);
    localparam logic [PhaseW-1:0]  PhaseLimit    = PhaseW'(704 + 20 * 65535);
    localparam logic [RecipW-1:0]  RecipMul      = RecipW'(2979);
    localparam logic [SampleW-1:0] CentreValue   = SampleW'(128);
    localparam logic [LevelW-1:0]  LevelFull     = LevelW'(7);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INVERT_PERIOD = 2'd0,
        CFG_VOLUME_LEVEL  = 2'd1,
        CFG_SOUND_DISABLE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_TAIL,
        ST_MUL,
        ST_DIV,
        ST_VOL
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOOP,
        OP_TAIL,
        OP_MUL,
        OP_DIV,
        OP_VOL
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_interval;
        logic loop_end;
    } t_dp_stat;

    typedef struct packed {
        logic [PeriodW-1:0] invert_period;
        logic [LevelW-1:0]  volume_level;
        logic               sound_disable;
    } t_cfg;

    function automatic logic [GainW-1:0] level_gain(input logic [LevelW-1:0] lvl);
        logic [GainW-1:0] g;
        unique case (lvl)
            3'd0:    g = 16'd8192;
            3'd1:    g = 16'd9362;
            3'd2:    g = 16'd10922;
            3'd3:    g = 16'd13107;
            3'd4:    g = 16'd16384;
            3'd5:    g = 16'd21845;
            3'd6:    g = 16'd32768;
            default: g = 16'd0;
        endcase
        return g;
    endfunction

    function automatic logic [SampleW-1:0] level_bias(input logic [LevelW-1:0] lvl);
        logic [SampleW-1:0] b;
        unique case (lvl)
            3'd0:    b = 8'd112;
            3'd1:    b = 8'd110;
            3'd2:    b = 8'd107;
            3'd3:    b = 8'd103;
            3'd4:    b = 8'd96;
            3'd5:    b = 8'd86;
            3'd6:    b = 8'd64;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### design/gass_ctrl.sv
`include "gated_audio_sample_scaler_macros.svh"

module gass_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  gass_pkg::t_cfg      i_cfg,
    input  gass_pkg::t_dp_stat  i_stat,
    output gass_pkg::t_dp_ctrl  o_ctrl
);

    gass_pkg::t_state             r_state, n_state;
    logic                         r_out_valid, n_out_valid;
    logic                         in_xfer;

    assign o_stall = (r_state != gass_pkg::ST_IDLE);
    assign o_valid = r_out_valid;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gass_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_stall;
        o_ctrl.op    = gass_pkg::OP_NONE;
        unique case (r_state)
            gass_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    o_ctrl.op = gass_pkg::OP_LOAD;
                    if ((i_cfg.invert_period == '0) || !i_stat.in_interval) begin
                        n_state = gass_pkg::ST_VOL;
                    end else begin
                        n_state = gass_pkg::ST_LOOP;
                    end
                end
            end
            gass_pkg::ST_LOOP: begin
                o_ctrl.op = gass_pkg::OP_LOOP;
                if (i_stat.loop_end) begin
                    n_state = gass_pkg::ST_TAIL;
                end
            end
            gass_pkg::ST_TAIL: begin
                o_ctrl.op = gass_pkg::OP_TAIL;
                n_state   = gass_pkg::ST_MUL;
            end
            gass_pkg::ST_MUL: begin
                o_ctrl.op = gass_pkg::OP_MUL;
                n_state   = gass_pkg::ST_DIV;
            end
            gass_pkg::ST_DIV: begin
                o_ctrl.op = gass_pkg::OP_DIV;
                n_state   = gass_pkg::ST_VOL;
            end
            gass_pkg::ST_VOL: begin
                if (!(r_out_valid && i_stall)) begin
                    o_ctrl.op   = gass_pkg::OP_VOL;
                    n_out_valid = 1'b1;
                    n_state     = gass_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gass_pkg::ST_IDLE;
            end
        endcase
    end

    `GASS_ASSERT_NXT(a_busy_after_xfer, in_xfer, r_state != gass_pkg::ST_IDLE)
    `GASS_ASSERT_NXT(a_valid_held, r_out_valid && i_stall, r_out_valid)
    `GASS_ASSERT_IMP(a_out_from_vol, $rose(r_out_valid), $past(r_state) == gass_pkg::ST_VOL)

endmodule

### design/gass_dp.sv
`include "gated_audio_sample_scaler_macros.svh"

module gass_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gass_pkg::t_cfg                i_cfg,
    input  gass_pkg::t_dp_ctrl            i_ctrl,
    input  logic [gass_pkg::SampleW-1:0]  i_sample_byte,
    output gass_pkg::t_dp_stat            o_stat,
    output logic [gass_pkg::SampleW-1:0]  o_sample_out
);

    logic [gass_pkg::PhaseW-1:0]   r_phase, n_phase;
    logic                          r_gate_on, n_gate_on;
    logic [gass_pkg::SampleW-1:0]  r_x, n_x;
    logic [gass_pkg::OffW-1:0]     r_off, n_off;
    logic [gass_pkg::OffW-1:0]     r_prev, n_prev;
    logic [gass_pkg::ProdW-1:0]    r_prod, n_prod;
    logic [gass_pkg::SampleW-1:0]  r_out, n_out;

    logic [gass_pkg::PhaseW-1:0]     step;
    logic [gass_pkg::PhaseW-1:0]     phase_add;
    logic [gass_pkg::RecipProdW-1:0] recip_prod;
    logic [gass_pkg::VolProdW-1:0]   vol_prod;

    // 20 * period as 16p + 4p
    assign step = gass_pkg::PhaseW'({i_cfg.invert_period, 4'b0000})
                + gass_pkg::PhaseW'({i_cfg.invert_period, 2'b00});
    assign phase_add = r_phase + step;

    // divide by 704: drop six bits, then multiply by the reciprocal of 11
    assign recip_prod =
        gass_pkg::RecipProdW'(r_prod[gass_pkg::ProdW-1:gass_pkg::IntervalLog2])
        * gass_pkg::RecipProdW'(gass_pkg::RecipMul);

    assign vol_prod = gass_pkg::VolProdW'(r_x)
                    * gass_pkg::VolProdW'(gass_pkg::level_gain(i_cfg.volume_level));

    assign o_stat.in_interval = (r_phase < gass_pkg::IntervalUnits);
    assign o_stat.loop_end    = (phase_add >= gass_pkg::IntervalUnits);
    assign o_sample_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_gate_on <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_gate_on <= n_gate_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_off  <= n_off;
        r_prev <= n_prev;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    always_comb begin
        n_phase   = r_phase;
        n_gate_on = r_gate_on;
        n_x       = r_x;
        n_off     = r_off;
        n_prev    = r_prev;
        n_prod    = r_prod;
        n_out     = r_out;
        unique case (i_ctrl.op)
            gass_pkg::OP_NONE: begin
            end
            gass_pkg::OP_LOAD: begin
                if (i_cfg.invert_period == '0) begin
                    n_x = i_cfg.sound_disable ? gass_pkg::CentreValue : i_sample_byte;
                end else if (o_stat.in_interval) begin
                    n_x    = i_sample_byte;
                    n_off  = '0;
                    n_prev = '0;
                end else begin
                    n_x     = r_gate_on ? '0 : i_sample_byte;
                    n_phase = r_phase - gass_pkg::IntervalUnits;
                end
            end
            gass_pkg::OP_LOOP: begin
                if (!r_gate_on) begin
                    n_off = r_off + (r_phase[gass_pkg::OffW-1:0] - r_prev);
                end
                n_gate_on = !r_gate_on;
                n_prev    = r_phase[gass_pkg::OffW-1:0];
                n_phase   = phase_add;
            end
            gass_pkg::OP_TAIL: begin
                if (!r_gate_on) begin
                    n_off = r_off + (gass_pkg::OffW'(gass_pkg::IntervalUnits) - r_prev);
                end
                n_phase = r_phase - gass_pkg::IntervalUnits;
            end
            gass_pkg::OP_MUL: begin
                n_prod = gass_pkg::ProdW'(r_x) * gass_pkg::ProdW'(r_off);
            end
            gass_pkg::OP_DIV: begin
                n_x = recip_prod[gass_pkg::RecipShift +: gass_pkg::SampleW];
            end
            gass_pkg::OP_VOL: begin
                if (i_cfg.volume_level == gass_pkg::LevelFull) begin
                    n_out = r_x;
                end else begin
                    n_out = vol_prod[gass_pkg::VolProdW-1:gass_pkg::GainW]
                          + gass_pkg::level_bias(i_cfg.volume_level);
                end
            end
            default: begin
            end
        endcase
    end

    `GASS_ASSERT_IMP(a_phase_bound, 1'b1, r_phase < gass_pkg::PhaseLimit)
    `GASS_ASSERT_IMP(a_off_bound, i_ctrl.op == gass_pkg::OP_MUL, r_off <= gass_pkg::OffW'(704))
    `GASS_ASSERT_IMP(a_loop_phase, i_ctrl.op == gass_pkg::OP_LOOP, o_stat.in_interval)

endmodule

### design/gated_audio_sample_scaler.sv
// With a zero period, or with the phase already past the interval, a transfer goes
// straight to the volume step; when the gate runs, the toggle loop on the phase adder
// (1 to 36 toggles) is followed by TAIL, one multiply and a reciprocal divide by 704,
// then the volume step. A new sample is taken only in idle, and the volume step waits
// while the output is stalled.
// Reset (sync, active low): phase and gate cleared, period 0, volume 7, sound enabled.
module gated_audio_sample_scaler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [gass_pkg::SampleW-1:0]   i_sample_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gass_pkg::SampleW-1:0]   o_sample_out,
    input  logic                           i_cfg_wr_en,
    input  logic [gass_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [gass_pkg::CfgDataW-1:0]  i_cfg_data
);

    logic [gass_pkg::PeriodW-1:0]  r_invert_period;
    logic [gass_pkg::LevelW-1:0]   r_volume_level;
    logic                          r_sound_disable;

    gass_pkg::t_cfg      cfg;
    gass_pkg::t_dp_ctrl  dp_ctrl;
    gass_pkg::t_dp_stat  dp_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_period <= '0;
            r_volume_level  <= gass_pkg::LevelFull;
            r_sound_disable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gass_pkg::CFG_INVERT_PERIOD: begin
                    r_invert_period <= i_cfg_data[gass_pkg::PeriodW-1:0];
                end
                gass_pkg::CFG_VOLUME_LEVEL: begin
                    r_volume_level <= i_cfg_data[gass_pkg::LevelW-1:0];
                end
                gass_pkg::CFG_SOUND_DISABLE: begin
                    r_sound_disable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.invert_period = r_invert_period;
    assign cfg.volume_level  = r_volume_level;
    assign cfg.sound_disable = r_sound_disable;

    gass_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_cfg   (cfg),
        .i_stat  (dp_stat),
        .o_ctrl  (dp_ctrl)
    );

    gass_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_ctrl        (dp_ctrl),
        .i_sample_byte (i_sample_byte),
        .o_stat        (dp_stat),
        .o_sample_out  (o_sample_out)
    );

endmodule
